// ===== sv/nec_ir_frame_transmitter_top_defines.svh =====
// ----------------------------------------------------------------------------
// NEC infrared transmitter assertion macros
// Assertion macros shared by the NEC infrared transmitter modules.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef NEC_IR_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define NEC_IR_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nec_ir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC infrared transmitter package
// Shared types, protocol timings, opcodes and register indexes.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

  localparam int RepeatsPerBatchDefault = 5;
  localparam int QueueDepthDefault      = 2;
  localparam int FramePairs             = 34;

  localparam int MarkW  = 14;
  localparam int SpaceW = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // Opcodes of the event channel.
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_DONE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ADDRESS_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADDRESS_HIGH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FRAME_PERIOD_US = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BUSY_TIMEOUT_US = 3'd3;

  // Pulse timings in microseconds.
  localparam logic [MarkW-1:0]  LEAD_MARK      = 14'd9000;
  localparam logic [SpaceW-1:0] LEAD_SPACE     = 17'd4500;
  localparam logic [MarkW-1:0]  BIT_MARK       = 14'd560;
  localparam logic [SpaceW-1:0] ZERO_SPACE     = 17'd560;
  localparam logic [SpaceW-1:0] ONE_SPACE      = 17'd1690;
  localparam logic [MarkW-1:0]  STOP_MARK      = 14'd560;
  localparam logic [SpaceW-1:0] STOP_SPACE     = 17'd500;
  localparam logic [SpaceW-1:0] REP_LEAD_SPACE = 17'd2250;
  localparam logic [SpaceW-1:0] REP_TAIL_SPACE = 17'd99190;

  typedef enum logic [1:0] {
    JOB_FRAME,
    JOB_GAP_REPEAT,
    JOB_REPEAT
  } job_kind_t;

  // Work handed from the classifier to the pulse sequencer.
  typedef struct packed {
    job_kind_t         kind;
    logic [31:0]       word;
    logic [SpaceW-1:0] gap;
  } job_t;

endpackage

// ===== sv/nec_ir_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one timestamped event per beat.
// ----------------------------------------------------------------------------
interface nec_ir_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  command;
  logic [31:0] now_us;

  modport source (output valid, op, command, now_us, input ready);
  modport sink   (input valid, op, command, now_us, output ready);
endinterface

// ===== sv/nec_ir_pulse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse channel
// Valid/ready channel carrying one mark/space pair per beat.
// ----------------------------------------------------------------------------
interface nec_ir_pulse_if;
  logic        valid;
  logic        ready;
  logic [13:0] mark_us;
  logic [16:0] space_us;
  logic        last;

  modport source (output valid, mark_us, space_us, last, input ready);
  modport sink   (input valid, mark_us, space_us, last, output ready);
endinterface

// ===== sv/nec_ir_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC infrared event classifier
// Holds configuration and sequencer state, decides what each event does and
// queues a job for the pulse sequencer.
// ----------------------------------------------------------------------------
module nec_ir_front
  import nec_ir_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  nec_ir_req_if.sink          req,
  output logic                job_valid,
  input  logic                job_ready,
  output job_t                job
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DATA,
    MODE_REPEAT
  } mode_t;

  logic [7:0]        address_low;
  logic [7:0]        address_high;
  logic [SpaceW-1:0] frame_period_us;
  logic [19:0]       busy_timeout_us;

  mode_t       mode;
  logic [7:0]  previous_command;
  logic [31:0] frame_start_time;

  logic        accept;
  logic [31:0] elapsed;
  logic        stale;
  logic        send_go;
  logic        done_gap;
  logic        done_rep;

  assign req.ready = job_ready;
  assign accept    = req.valid && req.ready;
  assign elapsed   = req.now_us - frame_start_time;
  assign stale     = elapsed > {12'd0, busy_timeout_us};

  always_comb begin
    send_go  = 1'b0;
    done_gap = 1'b0;
    done_rep = 1'b0;
    unique case (req.op)
      OP_SEND: begin
        send_go = (req.command != previous_command) && ((mode == MODE_IDLE) || stale);
      end
      OP_DONE: begin
        done_gap = (mode == MODE_DATA);
        done_rep = (mode == MODE_REPEAT);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job.word = {~req.command, req.command, address_high, address_low};
    if ({15'd0, frame_period_us} > elapsed) begin
      job.gap = frame_period_us - elapsed[SpaceW-1:0];
    end else begin
      job.gap = '0;
    end
    priority if (send_go) begin
      job.kind = JOB_FRAME;
    end else if (done_gap) begin
      job.kind = JOB_GAP_REPEAT;
    end else begin
      job.kind = JOB_REPEAT;
    end
  end

  assign job_valid = req.valid && (send_go || done_gap || done_rep);

  always_ff @(posedge clk) begin
    if (rst) begin
      address_low      <= 8'd1;
      address_high     <= 8'd254;
      frame_period_us  <= 17'd108000;
      busy_timeout_us  <= 20'd300000;
      mode             <= MODE_IDLE;
      previous_command <= 8'd255;
      frame_start_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ADDRESS_LOW:     address_low     <= cfg_data[7:0];
          REG_ADDRESS_HIGH:    address_high    <= cfg_data[7:0];
          REG_FRAME_PERIOD_US: frame_period_us <= cfg_data[SpaceW-1:0];
          REG_BUSY_TIMEOUT_US: busy_timeout_us <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (send_go) begin
          mode             <= MODE_DATA;
          previous_command <= req.command;
          frame_start_time <= req.now_us;
        end else if (done_gap) begin
          mode <= MODE_REPEAT;
        end else if (req.op == OP_RELEASE) begin
          mode             <= MODE_IDLE;
          previous_command <= 8'd255;
        end
      end
    end
  end

endmodule

// ===== sv/nec_ir_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC infrared job queue
// Short first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_transmitter_top_defines.svh"

module nec_ir_queue
  import nec_ir_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != Full);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `NIR_ASSERT_NOW(a_count_bound, 1'b1, count <= Full, "queue holds more jobs than its depth")
  `NIR_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 1'b1, "queue fill count slipped")
  `NIR_ASSERT_NEXT(a_drain, pop && !push, count == $past(count) - 1'b1, "queue drain count slipped")

endmodule

// ===== sv/nec_ir_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC infrared pulse sequencer
// Expands one queued job into its mark/space pairs, one pair per cycle while
// the pulse channel does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_transmitter_top_defines.svh"

module nec_ir_back
  import nec_ir_pkg::*;
#(
  parameter int RepeatsPerBatch = RepeatsPerBatchDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  job_t          job,
  nec_ir_pulse_if.source pulse
);

  localparam int RepPairs = 2 * RepeatsPerBatch;
  localparam int MaxPairs = (FramePairs > RepPairs + 1) ? FramePairs : RepPairs + 1;
  localparam int CntW     = $clog2(MaxPairs);
  localparam logic [CntW-1:0] FrameEnd  = CntW'(FramePairs - 1);
  localparam logic [CntW-1:0] GapRepEnd = CntW'(RepPairs);
  localparam logic [CntW-1:0] RepEnd    = CntW'(RepPairs - 1);

  logic              busy;
  job_kind_t         kind;
  logic [31:0]       word;
  logic [SpaceW-1:0] gap;
  logic [CntW-1:0]   cnt;

  logic              adv;
  logic              is_last;
  logic              rep_tail;
  logic [MarkW-1:0]  mark_next;
  logic [SpaceW-1:0] space_next;

  assign adv       = busy && (!pulse.valid || pulse.ready);
  assign job_ready = !busy || (adv && is_last);

  // Odd repeat pairs are the short tail; the gap pair shifts the parity by one.
  assign rep_tail = cnt[0] ^ (kind == JOB_GAP_REPEAT);

  always_comb begin
    unique case (kind)
      JOB_FRAME:      is_last = (cnt == FrameEnd);
      JOB_GAP_REPEAT: is_last = (cnt == GapRepEnd);
      default:        is_last = (cnt == RepEnd);
    endcase
    priority if (kind == JOB_FRAME) begin
      if (cnt == '0) begin
        mark_next  = LEAD_MARK;
        space_next = LEAD_SPACE;
      end else if (cnt == FrameEnd) begin
        mark_next  = STOP_MARK;
        space_next = STOP_SPACE;
      end else begin
        mark_next  = BIT_MARK;
        space_next = word[0] ? ONE_SPACE : ZERO_SPACE;
      end
    end else if (kind == JOB_GAP_REPEAT && cnt == '0) begin
      mark_next  = '0;
      space_next = gap;
    end else if (rep_tail) begin
      mark_next  = BIT_MARK;
      space_next = REP_TAIL_SPACE;
    end else begin
      mark_next  = LEAD_MARK;
      space_next = REP_LEAD_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= '0;
      pulse.valid <= 1'b0;
    end else begin
      if (adv) begin
        pulse.valid <= 1'b1;
      end else if (pulse.ready) begin
        pulse.valid <= 1'b0;
      end
      if (job_valid && job_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (adv) begin
        busy <= !is_last;
        cnt  <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      kind <= job.kind;
      word <= job.word;
      gap  <= job.gap;
    end else if (adv && kind == JOB_FRAME && cnt != '0) begin
      word <= {1'b0, word[31:1]};
    end
    if (adv) begin
      pulse.mark_us  <= mark_next;
      pulse.space_us <= space_next;
      pulse.last     <= is_last;
    end
  end

  `NIR_ASSERT_NEXT(a_load, job_valid && job_ready, busy && cnt == '0, "job load did not start a run")
  `NIR_ASSERT_NEXT(a_last_flag, adv && is_last, pulse.valid && pulse.last, "final pair lost its last flag")
  `NIR_ASSERT_NEXT(a_run_end, adv && is_last && !job_valid, !busy, "sequencer ran past the final pair")

endmodule

// ===== sv/nec_ir_frame_transmitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC infrared frame transmitter
// Turns timestamped send, done and release events into NEC mark/space pairs.
// ----------------------------------------------------------------------------
//   Channel | Direction | Beat carries
//   req     | in        | op, command, now_us
//   pulse   | out       | mark_us, space_us, last
//   cfg     | in        | cfg_index, cfg_data (write only)
//
// An event is classified in the cycle it is accepted; work goes into a two
// entry job queue. The sequencer emits one pair per cycle while the pulse
// channel does not stall: 34 pairs for a send, 2*RepeatsPerBatch (+1 for
// the gap) for a done event, with no bubble between jobs. The request side
// stalls only while the queue is full; a stalled pulse beat holds its value.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_top
  import nec_ir_pkg::*;
#(
  parameter int RepeatsPerBatch = RepeatsPerBatchDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  nec_ir_req_if.sink          req,
  nec_ir_pulse_if.source      pulse
);

  logic fq_valid;
  logic fq_ready;
  job_t fq_job;
  logic qb_valid;
  logic qb_ready;
  job_t qb_job;

  nec_ir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  nec_ir_queue #(
    .Depth (QueueDepthDefault)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  nec_ir_back #(
    .RepeatsPerBatch (RepeatsPerBatch)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .pulse     (pulse)
  );

endmodule
